@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the key tracker modules.
// They expect i_clk and i_rst_n to exist in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset
`define FLTK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included
`define FLTK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/fltk_pkg.sv @@
// ---------------------------------------------------------------------------
// fltk_pkg
// Types and constants shared by the frame latched key state tracker.
// ---------------------------------------------------------------------------
package fltk_pkg;

    localparam int KEY_W = 8;

    // Item action codes
    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_QUERY   = 2'd3
    } t_action;

    // One input item
    typedef struct packed {
        t_action          action;
        logic [KEY_W-1:0] key_code;
    } t_item;

    // Visible state of one key
    typedef struct packed {
        logic pressed;
        logic released;
        logic held;
    } t_key_status;

endpackage

@@ sv/fltk_in_stage.sv @@
// ---------------------------------------------------------------------------
// fltk_in_stage
// Input register of the tracker: captures one item and holds it until the
// map stage takes it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fltk_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fltk_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_adv,
    output logic           o_valid,
    output fltk_pkg::t_item o_item
);
    import fltk_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    // Free when empty or when the held item moves on this cycle
    assign load    = !r_valid || i_adv;
    assign o_stall = !load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `FLTK_ASSERT(a_adv_needs_item, i_adv |-> r_valid, "advance without a held item")
    `FLTK_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !r_valid, "input stage not empty after reset")

endmodule

@@ sv/fltk_key_maps.sv @@
// ---------------------------------------------------------------------------
// fltk_key_maps
// Per-key bitmaps in flip-flops. Applies one item per update and returns the
// visible state of the item's key after the update.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fltk_key_maps #(
    parameter int NUM_KEYS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_upd,
    input  fltk_pkg::t_item     i_item,
    output fltk_pkg::t_key_status o_status
);
    import fltk_pkg::*;

    logic [NUM_KEYS-1:0] r_held,     n_held;
    logic [NUM_KEYS-1:0] r_pend_add, n_pend_add;
    logic [NUM_KEYS-1:0] r_pend_rem, n_pend_rem;
    logic [NUM_KEYS-1:0] r_vis_press, n_vis_press;
    logic [NUM_KEYS-1:0] r_rec_press, n_rec_press;
    logic [NUM_KEYS-1:0] r_vis_rel,  n_vis_rel;
    logic [NUM_KEYS-1:0] r_rec_rel,  n_rec_rel;
    logic [NUM_KEYS-1:0] sel;

    // Key decode; out-of-range codes select nothing
    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            sel[i] = (32'(i_item.key_code) == i);
        end
    end

    // Next map values for the item
    always_comb begin
        n_held      = r_held;
        n_pend_add  = r_pend_add;
        n_pend_rem  = r_pend_rem;
        n_vis_press = r_vis_press;
        n_rec_press = r_rec_press;
        n_vis_rel   = r_vis_rel;
        n_rec_rel   = r_rec_rel;
        case (i_item.action)
            ACT_TICK: begin
                // promote recordings, then adds before removes
                n_vis_press = r_rec_press;
                n_rec_press = '0;
                n_vis_rel   = r_rec_rel;
                n_rec_rel   = '0;
                n_held      = (r_held | r_pend_add) & ~r_pend_rem;
                n_pend_add  = '0;
                n_pend_rem  = '0;
            end
            ACT_PRESS: begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (sel[i]) begin
                        if (r_held[i]) begin
                            // cancel a pending release
                            if (r_pend_rem[i]) begin
                                n_pend_rem[i]  = 1'b0;
                                n_rec_press[i] = 1'b1;
                            end
                        end else begin
                            n_pend_add[i]  = 1'b1;
                            n_rec_press[i] = 1'b1;
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (sel[i]) begin
                        if (!r_held[i]) begin
                            // cancel a pending add
                            if (r_pend_add[i]) begin
                                n_pend_add[i] = 1'b0;
                                n_rec_rel[i]  = 1'b1;
                            end
                        end else begin
                            n_pend_rem[i] = 1'b1;
                            n_rec_rel[i]  = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // query: no change
            end
        endcase
    end

    // Lookup of the item's key after the update
    assign o_status.pressed  = |(n_vis_press & sel);
    assign o_status.released = |(n_vis_rel & sel);
    assign o_status.held     = |(n_held & sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pend_add  <= '0;
            r_pend_rem  <= '0;
            r_vis_press <= '0;
            r_rec_press <= '0;
            r_vis_rel   <= '0;
            r_rec_rel   <= '0;
        end else if (i_upd) begin
            r_held      <= n_held;
            r_pend_add  <= n_pend_add;
            r_pend_rem  <= n_pend_rem;
            r_vis_press <= n_vis_press;
            r_rec_press <= n_rec_press;
            r_vis_rel   <= n_vis_rel;
            r_rec_rel   <= n_rec_rel;
        end
    end

    `FLTK_ASSERT(a_pend_excl, (r_pend_add & r_pend_rem) == '0, "key pending add and remove")
    `FLTK_ASSERT(a_add_unheld, (r_pend_add & r_held) == '0, "pending add on a held key")
    `FLTK_ASSERT(a_tick_clears, (i_upd && i_item.action == ACT_TICK) |=> (r_rec_press == '0 && r_rec_rel == '0 && r_pend_add == '0), "tick left recordings set")

endmodule

@@ sv/frame_latched_key_state_tracker.sv @@
// Results: an accepted item waits in the input register and moves on into
// the result register when that register is free or drains.
// Throughput: one item per cycle unless i_stall holds a full result; the
// key bitmaps sit in flip-flops and are read and updated in the same cycle by the
// map stage. Reset: synchronous, active low; clears every bitmap and
// empties the input and result registers, so items are taken right after.
// ---------------------------------------------------------------------------
// frame_latched_key_state_tracker
// Tracks key press/release events and latches them per frame tick; every
// item returns the key's pressed, released and held flags.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_latched_key_state_tracker #(
    parameter int NUM_KEYS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_action,
    input  logic [fltk_pkg::KEY_W-1:0] i_key_code,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_pressed_this_frame,
    output logic                     o_released_this_frame,
    output logic                     o_held
);
    import fltk_pkg::*;

    t_item       in_item;
    t_item       s1_item;
    logic        s1_valid;
    logic        adv;
    t_key_status status;
    logic        r_out_valid;
    logic        n_out_valid;
    t_key_status r_out;

    assign in_item.action   = t_action'(i_action);
    assign in_item.key_code = i_key_code;

    fltk_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_stall (o_stall),
        .i_adv   (adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    fltk_key_maps #(
        .NUM_KEYS (NUM_KEYS)
    ) u_key_maps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (adv),
        .i_item   (s1_item),
        .o_status (status)
    );

    // Item moves into the result register when it is free or drains
    assign adv = s1_valid && (!r_out_valid || !i_stall);

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (adv) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= status;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_pressed_this_frame  = r_out.pressed;
    assign o_released_this_frame = r_out.released;
    assign o_held                = r_out.held;

    `FLTK_ASSERT(a_stall_when_full, o_stall |-> (r_out_valid && i_stall), "input stalled with result free")
    `FLTK_ASSERT_ALWAYS(a_rst_out_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule
